### src/b2d_pkg.sv
// Shared types and constants for the binary to decimal ASCII unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package b2d_pkg;

    // Default width of the converted word.
    localparam int VALUE_WIDTH_DEF = 32;

    // ASCII codes emitted by the unit.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Register port geometry and register indexes.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_ENABLE = '0;

    // Control that travels with a number from cell to cell.
    typedef struct packed {
        logic valid;
        logic neg;
    } b2d_ctl_t;

endpackage

`default_nettype wire

### src/b2d_cell.sv
// One double-dabble step: adjusts every BCD digit and shifts in one binary bit.
// Depends on b2d_pkg for the control struct.
`default_nettype none

module b2d_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int NUM_DIGITS  = 10
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire b2d_pkg::b2d_ctl_t         ctl_in,
    input  wire logic [VALUE_WIDTH-1:0]    bin_in,
    input  wire logic [4*NUM_DIGITS-1:0]   bcd_in,
    output b2d_pkg::b2d_ctl_t              ctl_out,
    output logic [VALUE_WIDTH-1:0]         bin_out,
    output logic [4*NUM_DIGITS-1:0]        bcd_out
);
    import b2d_pkg::*;

    localparam int BCD_W = 4 * NUM_DIGITS;

    b2d_ctl_t               ctl_reg;
    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [VALUE_WIDTH-1:0] bin_next;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_next;
    logic [BCD_W-1:0]       bcd_adj;

    // Add three to every digit of five or more, then shift the pair left by one.
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_in[4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = bcd_in[4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = bcd_in[4*d +: 4];
            end
        end
        bcd_next = {bcd_adj[BCD_W-2:0], bin_in[VALUE_WIDTH-1]};
        bin_next = {bin_in[VALUE_WIDTH-2:0], 1'b0};
    end

    // Control of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign bin_out = bin_reg;
    assign bcd_out = bcd_reg;

endmodule

`default_nettype wire

### src/b2d_serial.sv
// Output serializer: emits the sign and the significant digits, one per cycle unless chr_stall holds it.
// Depends on b2d_pkg for character codes and the control struct.
`default_nettype none

module b2d_serial #(
    parameter int NUM_DIGITS = 10
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire b2d_pkg::b2d_ctl_t       ld_ctl,
    input  wire logic [4*NUM_DIGITS-1:0] ld_bcd,
    output logic                         ld_ready,
    output logic [7:0]                   character,
    output logic                         last,
    output logic                         chr_valid,
    input  wire logic                    chr_stall
);
    import b2d_pkg::*;

    localparam int IDX_W = $clog2(NUM_DIGITS);

    logic             busy_reg;
    logic             busy_next;
    logic             neg_pending_reg;
    logic             neg_pending_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] top_idx;
    logic [3:0]       digit_reg [NUM_DIGITS];
    logic             chr_valid_reg;
    logic [7:0]       character_reg;
    logic [7:0]       character_next;
    logic             last_reg;
    logic             last_next;
    logic             out_load;
    logic             emit;
    logic             final_emit;
    logic             load;

    // Handshake between the held number and the output register.
    assign out_load   = !chr_valid_reg || !chr_stall;
    assign emit       = busy_reg && out_load;
    assign final_emit = emit && !neg_pending_reg && (idx_reg == '0);
    assign ld_ready   = !busy_reg || final_emit;
    assign load       = ld_ctl.valid && ld_ready;

    // Position of the most significant nonzero digit; zero gives digit 0.
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (ld_bcd[4*i +: 4] != 4'd0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    // Walk through the sign and the digits of the held number.
    always_comb
    begin
        busy_next        = busy_reg;
        neg_pending_next = neg_pending_reg;
        idx_next         = idx_reg;
        if (load)
        begin
            busy_next        = 1'b1;
            neg_pending_next = ld_ctl.neg;
            idx_next         = top_idx;
        end
        else if (final_emit)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            if (neg_pending_reg)
            begin
                neg_pending_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - IDX_W'(1);
            end
        end
    end

    // Character for the current position.
    always_comb
    begin
        if (neg_pending_reg)
        begin
            character_next = CHAR_MINUS;
            last_next      = 1'b0;
        end
        else
        begin
            character_next = CHAR_ZERO + {4'd0, digit_reg[idx_reg]};
            last_next      = (idx_reg == '0);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            chr_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (out_load)
            begin
                chr_valid_reg <= busy_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        neg_pending_reg <= neg_pending_next;
        idx_reg         <= idx_next;
        if (load)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digit_reg[i] <= ld_bcd[4*i +: 4];
            end
        end
        if (out_load)
        begin
            character_reg <= character_next;
            last_reg      <= last_next;
        end
    end

    assign chr_valid = chr_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

    // A minus sign is never the final character of a number.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (chr_valid_reg && (character_reg == CHAR_MINUS)) |-> !last_reg)
        else $error("minus sign marked as last character");

    // Only a minus sign or a decimal digit leaves the unit.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid_reg |-> ((character_reg == CHAR_MINUS) ||
                           ((character_reg >= CHAR_ZERO) &&
                            (character_reg <= CHAR_ZERO + 8'd9))))
        else $error("character outside sign and digits");

    // Emitting a pending sign clears it and keeps the number held.
    a_sign_held: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && neg_pending_reg && emit) |=> (busy_reg && !neg_pending_reg))
        else $error("sign emission lost the held number");

    // A new number is taken only when the previous one is done.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !final_emit) |-> !load)
        else $error("number loaded over a busy serializer");

endmodule

`default_nettype wire

### src/binary_to_decimal_ascii_unit.sv
// A request passes through the register row, one binary bit per stage, then the
// serializer's held-number registers, then the output register that drives character.
// Throughput: one character per cycle while chr_stall is low; a number has at most 11
// characters at the default width, and the next number is loaded as the last character of the previous one leaves.
// Reset clears all valid flags and sets output_enable to 1; there is no clearing pass.
// Top level of the binary to decimal ASCII unit; uses b2d_pkg, b2d_cell, b2d_serial.
`default_nettype none

module binary_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = b2d_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Register port.
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [b2d_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [b2d_pkg::APB_DATA_W-1:0] pwdata,
    output logic [b2d_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // Request channel.
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire logic [VALUE_WIDTH-1:0]         value,
    input  wire logic                           signed_mode,
    // Character channel.
    output logic                                chr_valid,
    input  wire logic                           chr_stall,
    output logic [7:0]                          character,
    output logic                                last
);
    import b2d_pkg::*;

    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W      = 4 * NUM_DIGITS;

    logic                   output_enable_reg;
    logic                   output_enable_next;
    logic                   cfg_write;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   pipe_en;
    logic                   ser_ready;

    b2d_ctl_t               ctl_c [VALUE_WIDTH+1];
    logic [VALUE_WIDTH-1:0] bin_c [VALUE_WIDTH+1];
    logic [BCD_W-1:0]       bcd_c [VALUE_WIDTH+1];

    // Register writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[APB_ADDR_W-1:2] == REG_OUTPUT_ENABLE);

    always_comb
    begin
        output_enable_next = output_enable_reg;
        if (cfg_write)
        begin
            output_enable_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_enable_reg <= 1'b1;
        end
        else
        begin
            output_enable_reg <= output_enable_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_OUTPUT_ENABLE)
        begin
            prdata[0] = output_enable_reg;
        end
    end

    // Sign and magnitude of the incoming word; disabled requests are dropped.
    assign neg = signed_mode && value[VALUE_WIDTH-1];
    assign mag = neg ? (~value + VALUE_WIDTH'(1)) : value;

    assign pipe_en   = !ctl_c[VALUE_WIDTH].valid || ser_ready;
    assign req_stall = !pipe_en;

    assign ctl_c[0].valid = req_valid && output_enable_reg;
    assign ctl_c[0].neg   = neg;
    assign bin_c[0]       = mag;
    assign bcd_c[0]       = '0;

    // Row of double-dabble cells, one binary bit per cell.
    for (genvar k = 0; k < VALUE_WIDTH; k++)
    begin : g_cell
        b2d_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .NUM_DIGITS  (NUM_DIGITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (pipe_en),
            .ctl_in  (ctl_c[k]),
            .bin_in  (bin_c[k]),
            .bcd_in  (bcd_c[k]),
            .ctl_out (ctl_c[k+1]),
            .bin_out (bin_c[k+1]),
            .bcd_out (bcd_c[k+1])
        );
    end

    // Character serializer at the end of the row.
    b2d_serial #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld_ctl    (ctl_c[VALUE_WIDTH]),
        .ld_bcd    (bcd_c[VALUE_WIDTH]),
        .ld_ready  (ser_ready),
        .character (character),
        .last      (last),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall)
    );

endmodule

`default_nettype wire
